/* src/ihex_enc_pkg.sv */
package ihex_enc_pkg;

  // Header bytes (length, address high, address low, type) plus checksum.
  localparam int unsigned JOB_BYTES = 5;

  localparam logic [6:0] CHAR_COLON   = 7'h3A;
  localparam logic [6:0] CHAR_NEWLINE = 7'h0A;

  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  localparam logic [3:0] HDR_DIGITS  = 4'd8;
  localparam logic [3:0] DATA_DIGITS = 4'd2;
  localparam logic [3:0] CS_DIGITS   = 4'd2;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_type;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       record_end;
  } out_word_t;

  // One unit of text work: an optional colon, a run of hex digits taken
  // from the byte list high nibble first, and an optional closing newline.
  typedef struct packed {
    logic                          colon;
    logic [JOB_BYTES-1:0][7:0]     bytes;
    logic [3:0]                    ndig;
    logic                          nl;
  } job_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] n;
    n = {3'b000, nib};
    if (nib < 4'd10) begin
      hex_char = 7'h30 + n;
    end else begin
      hex_char = 7'h37 + n;
    end
  endfunction

endpackage

/* src/ihex_enc_front.sv */
module ihex_enc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  ihex_enc_pkg::in_word_t in_word,
  output logic                  in_full,
  input  logic                  q_full,
  output logic                  q_wr,
  output ihex_enc_pkg::job_t    q_job
);
  import ihex_enc_pkg::*;

  logic [7:0] remain_r, remain_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       open_r, open_nxt;
  logic       accept;
  logic       trailer;
  logic [7:0] cs;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    open_nxt   = open_r;
    trailer    = 1'b0;
    q_wr       = 1'b0;
    q_job      = '0;
    if (in_word.cmd == CMD_HEADER) begin
      sum_nxt    = in_word.rec_len + in_word.rec_addr[15:8] + in_word.rec_addr[7:0]
                 + in_word.rec_type;
      remain_nxt = in_word.rec_len;
      trailer    = (in_word.rec_len == 8'd0);
      open_nxt   = !trailer;
      q_wr       = accept;
    end else begin
      sum_nxt    = sum_r + in_word.data_byte;
      remain_nxt = remain_r - 8'd1;
      trailer    = (remain_nxt == 8'd0);
      open_nxt   = !trailer;
      q_wr       = accept && open_r;
    end
    cs = 8'd0 - sum_nxt;
    if (in_word.cmd == CMD_HEADER) begin
      q_job.colon = 1'b1;
      q_job.bytes = {cs, in_word.rec_type, in_word.rec_addr[7:0],
                     in_word.rec_addr[15:8], in_word.rec_len};
      q_job.ndig  = trailer ? HDR_DIGITS + CS_DIGITS : HDR_DIGITS;
    end else begin
      q_job.colon = 1'b0;
      q_job.bytes = {8'd0, 8'd0, 8'd0, cs, in_word.data_byte};
      q_job.ndig  = trailer ? DATA_DIGITS + CS_DIGITS : DATA_DIGITS;
    end
    q_job.nl = trailer;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= 8'd0;
      sum_r    <= 8'd0;
      open_r   <= 1'b0;
    end else if (q_wr) begin
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      open_r   <= open_nxt;
    end
  end

endmodule

/* src/ihex_enc_fifo.sv */
module ihex_enc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ihex_enc_pkg::job_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output ihex_enc_pkg::job_t rd_data,
  output logic               empty
);
  import ihex_enc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + PW'(1);
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (empty || full) |-> (wp_r == rp_r))
    else $error("queue pointers disagree with count");

endmodule

/* src/ihex_enc_back.sv */
module ihex_enc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  ihex_enc_pkg::job_t     job,
  output logic                   job_take,
  output logic                   out_empty,
  input  logic                   out_pop,
  output ihex_enc_pkg::out_word_t out_word
);
  import ihex_enc_pkg::*;

  job_t       cur_r;
  logic       busy_r;
  logic       colon_r;
  logic [3:0] dig_r;
  logic       oval_r;
  out_word_t  oword_r, oword_nxt;
  logic       adv, last;
  logic [7:0] sel_byte;
  logic [3:0] nib;

  assign adv      = busy_r && (!oval_r || out_pop);
  assign job_take = job_valid && (!busy_r || (adv && last));
  assign sel_byte = cur_r.bytes[dig_r[3:1]];
  assign nib      = dig_r[0] ? sel_byte[3:0] : sel_byte[7:4];

  always_comb begin
    oword_nxt = '0;
    last      = 1'b0;
    if (colon_r) begin
      oword_nxt.ascii_char = CHAR_COLON;
    end else if (dig_r < cur_r.ndig) begin
      oword_nxt.ascii_char = hex_char(nib);
      last = (dig_r + 4'd1 == cur_r.ndig) && !cur_r.nl;
    end else begin
      oword_nxt.ascii_char = CHAR_NEWLINE;
      oword_nxt.record_end = 1'b1;
      last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur_r <= job;
    end
    if (adv) begin
      oword_r <= oword_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      colon_r <= 1'b0;
      dig_r   <= 4'd0;
      oval_r  <= 1'b0;
    end else begin
      if (job_take) begin
        busy_r  <= 1'b1;
        colon_r <= job.colon;
        dig_r   <= 4'd0;
      end else if (adv && last) begin
        busy_r <= 1'b0;
      end else if (adv) begin
        if (colon_r) begin
          colon_r <= 1'b0;
        end else begin
          dig_r <= dig_r + 4'd1;
        end
      end
      if (adv) begin
        oval_r <= 1'b1;
      end else if (out_pop) begin
        oval_r <= 1'b0;
      end
    end
  end

  assign out_empty = !oval_r;
  assign out_word  = oword_r;

  a_end_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && oword_r.record_end) |-> (oword_r.ascii_char == CHAR_NEWLINE))
    else $error("record_end on a character other than newline");

  a_colon_first: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && colon_r) |-> (dig_r == 4'd0))
    else $error("colon pending after digits started");

  a_dig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (dig_r <= cur_r.ndig))
    else $error("digit index ran past the job");

endmodule

/* src/intel_hex_record_encoder_top.sv */
// Intel HEX record encoder. Words in are either a header (cmd 0: length,
// 16-bit address, type) or a data byte (cmd 1); words out are single ASCII
// characters. A header gives ':' and eight uppercase hex digits; each data
// byte of an open record gives two digits; after the last byte, or straight
// after a header of length zero, the two checksum digits follow and then a
// newline with record_end set. A data byte with no record open is taken and
// dropped, and a header during an open record abandons it without trailer.
// The output side moves one character per cycle while the consumer pops, so
// a data byte yields two characters (five when it closes the record) and a
// header nine (twelve for length zero); the character sequencer feeds a
// single output register. Input words are accepted every cycle while the
// job queue between the classifying front end and the sequencer has room.
module intel_hex_record_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  ihex_enc_pkg::in_word_t  in_word,
  output logic                    out_empty,
  input  logic                    out_pop,
  output ihex_enc_pkg::out_word_t out_word
);
  import ihex_enc_pkg::*;

  // Jobs flow from the front end, which owns the record state and works
  // out the checksum, to the back end, which spells them out character by
  // character.
  job_t q_wr_job;
  job_t q_rd_job;
  logic q_wr;
  logic q_full;
  logic q_empty;
  logic q_rd;

  ihex_enc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_job   (q_wr_job)
  );

  ihex_enc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_wr_job),
    .full    (q_full),
    .rd_en   (q_rd),
    .rd_data (q_rd_job),
    .empty   (q_empty)
  );

  // The sequencer pulls the next job in the same cycle it emits the last
  // character of the current one, so there is no gap between jobs.
  ihex_enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (q_rd_job),
    .job_take  (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
